// File: hw/rtl/kawv_pkg.sv
// Shared types and constants for the keep-awake vote timer.
// No dependencies; used by every module of the block.
package kawv_pkg;

    localparam int HOLD_W = 17;
    localparam int SLOT_W = 4;

    typedef logic [HOLD_W-1:0] hold_t;

    // Request kinds carried by the req_type field.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // Classification of one counter as produced by the shared hold unit.
    typedef struct packed {
        logic  never_sleep;
        logic  positive;
        hold_t dec_value;
    } hold_class_t;

endpackage

// File: hw/rtl/keep_awake_vote_timer_top.sv
// Top level of the keep-awake vote timer: sequencer, flags and output register.
// Depends on kawv_pkg, kawv_hold_alu and kawv_slot_store.
//
//  channel | dir | beat fields                                   | handshake
//  s_      | in  | req_type, slot, hold_time                     | s_valid/s_ready
//  m_      | out | enter_sleep, exit_sleep, timer_on, asleep      | m_valid/m_ready
//
// A set beat, or a tick while the timer is stopped, goes straight to the finish
// state, which loads the output register and returns to idle, ready for input.
// A tick with the timer running scans one slot a cycle through the single hold
// unit, and a never-sleep slot ends the scan early.
// Reset clears all counters and flags. A held result does not block acceptance
// of the next beat, but that beat's result then waits in the sequencer and the
// input stays not ready until the output register has drained.
module keep_awake_vote_timer_top #(
    parameter int SLOTS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [kawv_pkg::SLOT_W-1:0]        s_slot,
    input  logic signed [kawv_pkg::HOLD_W-1:0] s_hold_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_enter_sleep,
    output logic                               m_exit_sleep,
    output logic                               m_timer_on,
    output logic                               m_asleep
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W = (IDX_W + 1 > kawv_pkg::SLOT_W) ? IDX_W + 1 : kawv_pkg::SLOT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             timer_reg, timer_next;
    logic             sleep_reg, sleep_next;
    logic             any_pos_reg, any_pos_next;
    logic             enter_reg, enter_next;
    logic             exit_reg, exit_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_enter_reg, m_enter_next;
    logic             m_exit_reg, m_exit_next;
    logic             m_timer_reg, m_timer_next;
    logic             m_asleep_reg, m_asleep_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    kawv_pkg::hold_t  wr_data;
    kawv_pkg::hold_t  rd_data;
    kawv_pkg::hold_class_t cls;

    logic [CMP_W-1:0] slot_ext;
    logic             slot_ok;
    logic             accept;
    logic             out_free;

    assign slot_ext = CMP_W'(s_slot);
    assign slot_ok  = slot_ext < CMP_W'(SLOTS);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    kawv_slot_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_idx  (idx_reg),
        .rd_data (rd_data)
    );

    kawv_hold_alu u_alu (
        .value (rd_data),
        .cls   (cls)
    );

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        timer_next    = timer_reg;
        sleep_next    = sleep_reg;
        any_pos_next  = any_pos_reg;
        enter_next    = enter_reg;
        exit_next     = exit_reg;
        wr_en         = 1'b0;
        wr_idx        = idx_reg;
        wr_data       = cls.dec_value;

        m_valid_next  = m_valid_reg && !m_ready;
        m_enter_next  = m_enter_reg;
        m_exit_next   = m_exit_reg;
        m_timer_next  = m_timer_reg;
        m_asleep_next = m_asleep_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    enter_next   = 1'b0;
                    exit_next    = 1'b0;
                    idx_next     = '0;
                    any_pos_next = 1'b0;
                    state_next   = ST_FINISH;
                    if (s_req_type == kawv_pkg::REQ_SET) begin
                        if (slot_ok) begin
                            wr_en      = 1'b1;
                            wr_idx     = slot_ext[IDX_W-1:0];
                            wr_data    = kawv_pkg::hold_t'(unsigned'(s_hold_time));
                            timer_next = 1'b1;
                            if (sleep_reg) begin
                                sleep_next = 1'b0;
                                exit_next  = 1'b1;
                            end
                        end
                    end else if (timer_reg) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cls.never_sleep) begin
                    // A never-sleep slot stops the timer and leaves later slots alone.
                    timer_next = 1'b0;
                    state_next = ST_FINISH;
                end else begin
                    if (cls.positive) begin
                        wr_en        = 1'b1;
                        any_pos_next = 1'b1;
                    end
                    if (idx_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = ST_FINISH;
                        if (!(any_pos_reg || cls.positive)) begin
                            timer_next = 1'b0;
                            if (!sleep_reg) begin
                                sleep_next = 1'b1;
                                enter_next = 1'b1;
                            end
                        end
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_enter_next  = enter_reg;
                    m_exit_next   = exit_reg;
                    m_timer_next  = timer_reg;
                    m_asleep_next = sleep_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            timer_reg   <= 1'b0;
            sleep_reg   <= 1'b0;
            any_pos_reg <= 1'b0;
            enter_reg   <= 1'b0;
            exit_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            timer_reg   <= timer_next;
            sleep_reg   <= sleep_next;
            any_pos_reg <= any_pos_next;
            enter_reg   <= enter_next;
            exit_reg    <= exit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_enter_reg  <= m_enter_next;
        m_exit_reg   <= m_exit_next;
        m_timer_reg  <= m_timer_next;
        m_asleep_reg <= m_asleep_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_enter_sleep = m_enter_reg;
    assign m_exit_sleep  = m_exit_reg;
    assign m_timer_on    = m_timer_reg;
    assign m_asleep      = m_asleep_reg;

endmodule

// File: hw/rtl/kawv_hold_alu.sv
// Shared hold unit: classifies one counter and forms its decremented value.
// Depends on kawv_pkg.
module kawv_hold_alu (
    input  kawv_pkg::hold_t       value,
    output kawv_pkg::hold_class_t cls
);

    always_comb begin
        // All ones is the never-sleep marker; other negatives count as expired.
        cls.never_sleep = &value;
        cls.positive    = (value != '0) && !value[kawv_pkg::HOLD_W-1];
        cls.dec_value   = value - kawv_pkg::hold_t'(1);
    end

endmodule

// File: hw/rtl/kawv_slot_store.sv
// Register file of per-slot hold counters, one write port and one read port.
// Depends on kawv_pkg.
module kawv_slot_store #(
    parameter int SLOTS = 10,
    parameter int IDX_W = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  kawv_pkg::hold_t       wr_data,
    input  logic [IDX_W-1:0]      rd_idx,
    output kawv_pkg::hold_t       rd_data
);

    kawv_pkg::hold_t counters_reg [SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                counters_reg[i] <= '0;
            end
        end else if (wr_en) begin
            counters_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = counters_reg[rd_idx];

endmodule

// File: dv/keep_awake_vote_timer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for keep_awake_vote_timer_top: directed and random beats,
// with a scoreboard class that predicts every result. Depends on kawv_pkg and the RTL.
module keep_awake_vote_timer_top_tb;

    localparam int SLOTS       = 10;
    localparam int N_ITEMS     = 800;
    localparam int QUIET_TAIL  = 100;
    localparam int LONG_STALL  = 400;

    typedef struct packed {
        logic enter_sleep;
        logic exit_sleep;
        logic timer_on;
        logic asleep;
    } vote_result_t;

    // Tracks the hold counters and flags and queues the result each beat should give.
    class sleep_vote_scoreboard;
        kawv_pkg::hold_t counters [SLOTS];
        bit           timer_running;
        bit           sleeping;
        vote_result_t pending [$];
        int           n_errors;
        int           n_sent;

        function new();
            foreach (counters[i]) counters[i] = '0;
            timer_running = 1'b0;
            sleeping      = 1'b0;
            n_errors      = 0;
            n_sent        = 0;
        endfunction

        function void note_request(logic kind, logic [kawv_pkg::SLOT_W-1:0] slot,
                                   kawv_pkg::hold_t hold);
            vote_result_t want;
            bit any_positive;
            bit never_sleep;
            want         = '0;
            any_positive = 1'b0;
            never_sleep  = 1'b0;
            n_sent++;
            if (kind == kawv_pkg::REQ_SET) begin
                if (slot < SLOTS) begin
                    counters[slot] = hold;
                    if (sleeping) begin
                        sleeping        = 1'b0;
                        want.exit_sleep = 1'b1;
                    end
                    timer_running = 1'b1;
                end
            end else if (timer_running) begin
                // A never-sleep slot ends the scan; later slots keep their counts.
                for (int i = 0; i < SLOTS && !never_sleep; i++) begin
                    if (counters[i] == '1) begin
                        never_sleep = 1'b1;
                    end else if (counters[i] != '0 && !counters[i][kawv_pkg::HOLD_W-1]) begin
                        counters[i]  = counters[i] - 1'b1;
                        any_positive = 1'b1;
                    end
                end
                if (never_sleep) begin
                    timer_running = 1'b0;
                end else if (!any_positive) begin
                    timer_running = 1'b0;
                    if (!sleeping) begin
                        sleeping         = 1'b1;
                        want.enter_sleep = 1'b1;
                    end
                end
            end
            want.timer_on = timer_running;
            want.asleep   = sleeping;
            pending.push_back(want);
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            n_errors++;
        endtask

        task check_result(vote_result_t got);
            vote_result_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %b", got));
            end else begin
                want = pending.pop_front();
                if (got.enter_sleep !== want.enter_sleep)
                    report($sformatf("enter_sleep %b, expected %b",
                                     got.enter_sleep, want.enter_sleep));
                if (got.exit_sleep !== want.exit_sleep)
                    report($sformatf("exit_sleep %b, expected %b",
                                     got.exit_sleep, want.exit_sleep));
                if (got.timer_on !== want.timer_on)
                    report($sformatf("timer_on %b, expected %b", got.timer_on, want.timer_on));
                if (got.asleep !== want.asleep)
                    report($sformatf("asleep %b, expected %b", got.asleep, want.asleep));
            end
        endtask
    endclass

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_req_type    = kawv_pkg::REQ_TICK;
    logic [kawv_pkg::SLOT_W-1:0] s_slot = '0;
    logic signed [kawv_pkg::HOLD_W-1:0] s_hold_time = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_enter_sleep;
    logic              m_exit_sleep;
    logic              m_timer_on;
    logic              m_asleep;

    sleep_vote_scoreboard sb = new();
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;

    keep_awake_vote_timer_top #(
        .SLOTS(SLOTS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_slot       (s_slot),
        .s_hold_time  (s_hold_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_enter_sleep(m_enter_sleep),
        .m_exit_sleep (m_exit_sleep),
        .m_timer_on   (m_timer_on),
        .m_asleep     (m_asleep)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic offer(input logic kind, input logic [kawv_pkg::SLOT_W-1:0] slot,
                         input kawv_pkg::hold_t hold);
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_slot      <= slot;
        s_hold_time <= hold;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, slot, hold);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic tick();
        offer(kawv_pkg::REQ_TICK, kawv_pkg::SLOT_W'($urandom), kawv_pkg::HOLD_W'($urandom));
    endtask

    task automatic random_beat();
        logic [kawv_pkg::SLOT_W-1:0] slot;
        kawv_pkg::hold_t             hold;
        int                          pick;
        if ($urandom_range(0, 99) < 50) begin
            tick();
        end else begin
            if ($urandom_range(0, 9) == 0)
                slot = kawv_pkg::SLOT_W'($urandom_range(SLOTS, 2**kawv_pkg::SLOT_W - 1));
            else
                slot = kawv_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
            // Mostly short holds so that the slots expire and the block sleeps often.
            pick = $urandom_range(0, 19);
            if (pick < 12)
                hold = kawv_pkg::HOLD_W'($urandom_range(0, 4));
            else if (pick < 14)
                hold = '1;
            else if (pick < 15)
                hold = {1'b1, 16'($urandom)};
            else if (pick < 17)
                hold = kawv_pkg::HOLD_W'($urandom);
            else
                hold = '0;
            offer(kawv_pkg::REQ_SET, slot, hold);
        end
    endtask

    initial begin : result_sink
        vote_result_t got;
        int           stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{m_enter_sleep, m_exit_sleep, m_timer_on, m_asleep};
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_STALL;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            m_ready <= (stall_left == 0);
        end
    end

    initial begin : stimulus
        bit stall_asked;
        int drain;
        stall_asked = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: expiry, sleeping, waking, never-sleep, odd holds and bad slots.
        tick();                                 // timer stopped after reset
        offer(kawv_pkg::REQ_SET, 4'd0, 17'sd2);
        tick();
        tick();
        tick();                                 // all expired: sleep request
        tick();                                 // stopped and asleep
        offer(kawv_pkg::REQ_SET, 4'd15, 17'sd5);    // slot out of range, stays asleep
        offer(kawv_pkg::REQ_SET, 4'd10, 17'sd0);
        offer(kawv_pkg::REQ_SET, 4'd3, -17'sd1);    // wakes, never sleep
        offer(kawv_pkg::REQ_SET, 4'd5, 17'sd65535);
        tick();                                 // scan stops at slot 3, slot 5 untouched
        tick();                                 // stopped while awake
        offer(kawv_pkg::REQ_SET, 4'd3, -17'sd65536);
        offer(kawv_pkg::REQ_SET, 4'd9, 17'sd1);
        tick();
        offer(kawv_pkg::REQ_SET, 4'd5, 17'sd0);
        tick();                                 // negative hold counts as expired
        offer(kawv_pkg::REQ_SET, 4'd1, -17'sd2);    // wakes
        tick();
        offer(kawv_pkg::REQ_SET, 4'd9, 17'h0AAAA);
        offer(kawv_pkg::REQ_SET, 4'd9, 17'h15555);
        tick();

        while (sb.n_sent < N_ITEMS) begin
            if (!stall_asked && sb.n_sent >= 300) begin
                stall_asked   = 1'b1;
                long_hold_req = 1'b1;
            end
            if (sb.n_sent >= N_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            random_beat();
        end
        s_valid <= 1'b0;

        drain = 0;
        while (sb.pending.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (4 * SLOTS) @(posedge aclk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));

        if (sb.n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/kawv_pkg.sv
hw/rtl/kawv_hold_alu.sv
hw/rtl/kawv_slot_store.sv
hw/rtl/keep_awake_vote_timer_top.sv
dv/keep_awake_vote_timer_top_tb.sv
